### design/dfs_pkg.sv
package dfs_pkg;

  // field widths fixed by the item format
  localparam int NODE_W   = 4;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int NCOUNT_W = 5;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // input function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_EDGE   = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNREACH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  // classified commands
  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_EDGE      = 2'd1,
    OP_SEARCH    = 2'd2,
    OP_RANGE_ERR = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic [NODE_W-1:0]   node;
    logic                last;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

### design/dfs_path_finder.sv
// depth-first path finder over a small undirected graph
//
// items: start_i with func_i, node_a_i, node_b_i is taken at a clock edge
// where busy_o is low. func 0 clears the graph, func 1 adds an edge, func 2
// searches from node_a_i and emits the path to node_b_i. clear and edge
// items give no result; a search gives one result per path node, source
// first, last_o on the final one, or a single result with an error status.
// results appear on valid_o for one cycle each and cannot be held off.
// items go through a two-entry command queue; busy_o is high while it is
// full, so the next items are taken while a search is still running.
// clear and edge are handled in the engine's idle state. a search pops the
// stack through the pop and read states (the stack memory read is
// registered), scans the N matrix bits of each visited node one per cycle,
// then walks the L path nodes back from the destination and emits them.
// node_count (apb address 0) sets the nodes in use; write it only while idle.
// reset empties the graph, the queue and the stack and sets node_count to 16.
module dfs_path_finder import dfs_pkg::*; #(
  parameter int MAX_NODES   = 16,
  parameter int STACK_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [NODE_W-1:0]     node_a_i,
  input  logic [NODE_W-1:0]     node_b_i,
  output logic                  valid_o,
  output logic [NODE_W-1:0]     path_node_o,
  output logic                  last_o,
  output logic [STATUS_W-1:0]   status_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > NCOUNT_W) ? CNT_W : NCOUNT_W;

  logic [NCOUNT_W-1:0] node_count_q;
  logic [CMP_W-1:0]    nc_ext;
  logic [CNT_W-1:0]    n_eff;
  logic                q_push;
  cmd_t                q_cmd;
  logic                q_pop;
  cmd_t                q_head;
  logic                q_empty;
  logic                q_full;
  res_t                res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
      node_count_q <= pwdata[NCOUNT_W-1:0];
    end
  end

  // effective node count, clamped to 1..MAX_NODES
  assign nc_ext = CMP_W'(node_count_q);
  always_comb begin
    if (nc_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (nc_ext > CMP_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(nc_ext);
    end
  end

  assign busy_o = q_full;

  // item intake and classification
  dfs_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .start_i (start_i),
    .func_i  (func_i),
    .node_a_i(node_a_i),
    .node_b_i(node_b_i),
    .n_eff_i (n_eff),
    .full_i  (q_full),
    .push_o  (q_push),
    .cmd_o   (q_cmd)
  );

  // command queue
  dfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .pop_i  (q_pop),
    .head_o (q_head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // graph store and search engine
  dfs_back #(
    .MAX_NODES  (MAX_NODES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_eff_i(n_eff),
    .head_i (q_head),
    .empty_i(q_empty),
    .pop_o  (q_pop),
    .res_o  (res)
  );

  assign valid_o     = res.valid;
  assign path_node_o = res.node;
  assign last_o      = res.last;
  assign status_o    = res.status;

endmodule

### design/dfs_ram.sv
module dfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/dfs_front.sv
module dfs_front import dfs_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic                           start_i,
  input  logic [FUNC_W-1:0]              func_i,
  input  logic [NODE_W-1:0]              node_a_i,
  input  logic [NODE_W-1:0]              node_b_i,
  input  logic [$clog2(MAX_NODES+1)-1:0] n_eff_i,
  input  logic                           full_i,
  output logic                           push_o,
  output cmd_t                           cmd_o
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > NODE_W) ? CNT_W : NODE_W;

  logic accept;
  logic a_ok;
  logic b_ok;

  assign accept = start_i && !full_i;
  assign a_ok   = CMP_W'(node_a_i) < CMP_W'(n_eff_i);
  assign b_ok   = CMP_W'(node_b_i) < CMP_W'(n_eff_i);

  // classify the item; dropped items never reach the queue
  always_comb begin
    push_o        = 1'b0;
    cmd_o.op      = OP_CLEAR;
    cmd_o.node_a  = node_a_i;
    cmd_o.node_b  = node_b_i;
    case (func_i)
      FUNC_CLEAR: begin
        push_o   = accept;
        cmd_o.op = OP_CLEAR;
      end
      FUNC_EDGE: begin
        push_o   = accept && a_ok && b_ok;
        cmd_o.op = OP_EDGE;
      end
      FUNC_SEARCH: begin
        push_o   = accept;
        cmd_o.op = (a_ok && b_ok) ? OP_SEARCH : OP_RANGE_ERR;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

### design/dfs_queue.sv
module dfs_queue import dfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

### design/dfs_back.sv
module dfs_back import dfs_pkg::*; #(
  parameter int MAX_NODES   = 16,
  parameter int STACK_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(MAX_NODES+1)-1:0] n_eff_i,
  input  cmd_t                           head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output res_t                           res_o
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int NROWS = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int NB_W  = $clog2(NROWS);
  localparam int NL_W  = $clog2(NROWS + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP  = 6'b000010,
    S_READ = 6'b000100,
    S_SCAN = 6'b001000,
    S_WALK = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [NB_W-1:0]   src_q, src_d;
  logic [NB_W-1:0]   dst_q, dst_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [NB_W-1:0]   cur_q, cur_d;
  logic [NROWS-1:0]  row_q, row_d;
  logic [NB_W-1:0]   nb_q, nb_d;
  logic [NL_W-1:0]   len_q, len_d;
  logic [NB_W-1:0]   node_q, node_d;
  res_t              res_q, res_d;

  logic [NROWS-1:0]  adj_q [NROWS];
  logic [NROWS-1:0]  visited_q;
  logic [NROWS-1:0]  pvalid_q;
  logic [NB_W-1:0]   parent_q [NROWS];
  logic [NB_W-1:0]   path_q [NROWS];

  logic              adj_clr;
  logic              adj_set;
  logic              vis_clr;
  logic              vis_set;
  logic              par_we;
  logic              path_we;
  logic [NB_W-1:0]   edge_a;
  logic [NB_W-1:0]   edge_b;
  logic [NB_W-1:0]   rd_cur;
  logic [NL_W-1:0]   nlim;
  logic [NL_W-1:0]   ptr;
  logic [SP_W-1:0]   sp_dec;

  logic              ram_we;
  logic [SA_W-1:0]   ram_waddr;
  logic [NB_W-1:0]   ram_wdata;
  logic [SA_W-1:0]   ram_raddr;
  logic [NB_W-1:0]   ram_rdata;

  // search stack
  dfs_ram #(
    .WIDTH(NB_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // scan limit: nodes above the stored rows carry no edges
  assign nlim   = (n_eff_i > CNT_W'(NROWS)) ? NL_W'(NROWS) : NL_W'(n_eff_i);
  assign edge_a = NB_W'(head_i.node_a);
  assign edge_b = NB_W'(head_i.node_b);
  assign rd_cur = ram_rdata;
  assign ptr    = len_q - NL_W'(1);
  assign sp_dec = sp_q - SP_W'(1);
  assign res_o  = res_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    dst_d     = dst_q;
    sp_d      = sp_q;
    cur_d     = cur_q;
    row_d     = row_q;
    nb_d      = nb_q;
    len_d     = len_q;
    node_d    = node_q;
    res_d     = '0;
    pop_o     = 1'b0;
    adj_clr   = 1'b0;
    adj_set   = 1'b0;
    vis_clr   = 1'b0;
    vis_set   = 1'b0;
    par_we    = 1'b0;
    path_we   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_CLEAR: begin
              adj_clr = 1'b1;
            end
            OP_EDGE: begin
              adj_set = 1'b1;
            end
            OP_RANGE_ERR: begin
              res_d.valid  = 1'b1;
              res_d.last   = 1'b1;
              res_d.status = STATUS_RANGE;
            end
            OP_SEARCH: begin
              src_d     = edge_a;
              dst_d     = edge_b;
              vis_clr   = 1'b1;
              ram_we    = 1'b1;
              ram_wdata = edge_a;
              sp_d      = SP_W'(1);
              state_d   = S_POP;
            end
            default: begin
              adj_clr = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          if (visited_q[dst_q]) begin
            node_d  = dst_q;
            len_d   = '0;
            state_d = S_WALK;
          end else begin
            res_d.valid  = 1'b1;
            res_d.last   = 1'b1;
            res_d.status = STATUS_UNREACH;
            state_d      = S_IDLE;
          end
        end else begin
          sp_d      = sp_dec;
          ram_raddr = sp_dec[SA_W-1:0];
          state_d   = S_READ;
        end
      end
      S_READ: begin
        if ((NL_W'(rd_cur) < nlim) && !visited_q[rd_cur]) begin
          vis_set = 1'b1;
          cur_d   = rd_cur;
          row_d   = adj_q[rd_cur] & ~(visited_q | (NROWS'(1) << rd_cur));
          nb_d    = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_POP;
        end
      end
      S_SCAN: begin
        // one neighbor per cycle, ascending
        if (row_q[nb_q]) begin
          par_we = 1'b1;
          if (sp_q < SP_W'(STACK_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = sp_q[SA_W-1:0];
            ram_wdata = nb_q;
            sp_d      = sp_q + SP_W'(1);
          end
        end
        nb_d = nb_q + NB_W'(1);
        if (NL_W'(nb_q) + NL_W'(1) == nlim) begin
          state_d = S_POP;
        end
      end
      S_WALK: begin
        // follow parents from destination back to source
        if (len_q == NL_W'(NROWS)) begin
          res_d.valid  = 1'b1;
          res_d.last   = 1'b1;
          res_d.status = STATUS_UNREACH;
          state_d      = S_IDLE;
        end else begin
          path_we = 1'b1;
          len_d   = len_q + NL_W'(1);
          if (node_q == src_q) begin
            state_d = S_EMIT;
          end else if (!pvalid_q[node_q]) begin
            res_d.valid  = 1'b1;
            res_d.last   = 1'b1;
            res_d.status = STATUS_UNREACH;
            state_d      = S_IDLE;
          end else begin
            node_d = parent_q[node_q];
          end
        end
      end
      S_EMIT: begin
        // path buffer read backwards, source first
        res_d.valid  = 1'b1;
        res_d.node   = NODE_W'(path_q[ptr[NB_W-1:0]]);
        res_d.last   = ptr == '0;
        res_d.status = STATUS_OK;
        len_d        = ptr;
        if (ptr == '0) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      res_q   <= res_d;
    end
  end

  // search working registers
  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    dst_q  <= dst_d;
    cur_q  <= cur_d;
    row_q  <= row_d;
    nb_q   <= nb_d;
    len_q  <= len_d;
    node_q <= node_d;
  end

  // adjacency matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NROWS; r++) begin
        adj_q[r] <= '0;
      end
    end else if (adj_clr) begin
      for (int r = 0; r < NROWS; r++) begin
        adj_q[r] <= '0;
      end
    end else if (adj_set) begin
      adj_q[edge_a][edge_b] <= 1'b1;
      adj_q[edge_b][edge_a] <= 1'b1;
    end
  end

  // visited and parent valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      pvalid_q  <= '0;
    end else if (vis_clr) begin
      visited_q <= '0;
      pvalid_q  <= '0;
    end else begin
      if (vis_set) begin
        visited_q[rd_cur] <= 1'b1;
      end
      if (par_we) begin
        pvalid_q[nb_q] <= 1'b1;
      end
    end
  end

  // parent links and path buffer
  always_ff @(posedge clk_i) begin
    if (par_we) begin
      parent_q[nb_q] <= cur_q;
    end
    if (path_we) begin
      path_q[len_q[NB_W-1:0]] <= node_q;
    end
  end

  // a path run comes out in consecutive cycles
  a_path_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.valid && !res_q.last) |=> res_q.valid)
    else $error("path run broken before last item");

  // stack pointer stays within the stack
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // neighbor scan stays below the node limit
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (NL_W'(nb_q) < nlim))
    else $error("neighbor scan out of range");

  // a new search starts from clean flags and a one-entry stack
  a_search_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !empty_i && head_i.op == OP_SEARCH) |=>
    (visited_q == '0 && pvalid_q == '0 && sp_q == SP_W'(1)))
    else $error("search started with stale state");

endmodule
